FILE: rtl/hpc_pkg.sv
// shared constants and codes of the histogram probability and cdf block
package hpc_pkg;

   localparam int BINS_DEFAULT      = 256;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 8;
   localparam int SIZE_W   = 9;
   localparam int COUNT_W  = 32;
   localparam int FRAC_W   = 17;
   localparam int STATUS_W = 2;

   localparam logic [SIZE_W-1:0]  SIZE_RESET = 9'd256;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

endpackage

FILE: rtl/histogram_probability_cdf.sv
// histogram with per-key counts, probability and prefix-sum cdf over a shared divider
//
//   channel   direction  signals                      transfer carries
//   req       in         req_tvalid/tready/tdata/user  tuser: mode, tdata: key
//   rsp       out        rsp_tvalid/tready/tdata/user  tuser: status, tdata: count, fractions
//   csr       in         csr_valid/ready/data          number of keys in use
//
// for one item the prefix scan reads one count per cycle through the single
// memory port, and the shared restoring divider yields one quotient bit per cycle,
// used once for probability and once for cdf
// an item whose total is zero or whose key is out of domain skips the scan
// reset (synchronous, active high) empties the counts through valid bits at once
// the finished result sits in an output register, so the next item is taken while it
// waits; the result of that item is held back until the register is free
module histogram_probability_cdf
   import hpc_pkg::*;
#(
   parameter int BINS      = BINS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] key
   input  logic [MODE_W-1:0]   req_tuser,   // [1:0] mode
   // response channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,   // [31:0] key_count, [48:32] probability,
                                            // [65:49] cumulative, rest zero
   output logic [STATUS_W-1:0] rsp_tuser,   // [1:0] status
   // configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SIZE_W-1:0]   csr_data     // [8:0] number of keys in use
);

   // keys are 8 bits wide, so no entry above 255 can ever be addressed
   localparam int DEPTH = (BINS < 256) ? BINS : 256;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QW    = FRAC_BITS + 1;              // quotient including the integer bit
   localparam int QX    = (QW > FRAC_W) ? QW : FRAC_W;
   localparam int CW    = $clog2(FRAC_BITS);
   localparam logic [16:0]   BINS_W   = 17'(BINS);
   localparam logic [CW-1:0] LAST_BIT = CW'(FRAC_BITS - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_READ   = 8'b0000_0010,
      ST_UPDATE = 8'b0000_0100,
      ST_DIVLD  = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_SCAN   = 8'b0010_0000,
      ST_DRAIN  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration and bookkeeping
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;

   // item held over its work
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [FRAC_W-1:0]   prob_ff, prob_in;
   logic [FRAC_W-1:0]   cum_ff, cum_in;

   // prefix scan
   logic [AW-1:0]      idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [COUNT_W-1:0] prefix_ff, prefix_in;

   // shared divider
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] den_ff, den_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [CW-1:0]      bit_ff, bit_in;
   logic               second_ff, second_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [COUNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic [FRAC_W-1:0]   out_prob_ff, out_prob_in;
   logic [FRAC_W-1:0]   out_cum_ff, out_cum_in;

   // count memory, one port, registered read
   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic [AW-1:0]      mem_addr;
   logic               mem_we;
   logic [COUNT_W-1:0] mem_wdata;
   logic [COUNT_W-1:0] rd_count;

   logic [SIZE_W-1:0]  eff_size;
   logic               in_dom;
   logic               req_xfer;
   logic               out_free;

   // divider datapath
   logic [COUNT_W:0]   div_shift;
   logic               div_ge;
   logic [COUNT_W:0]   div_diff;
   logic [COUNT_W-1:0] div_numc;
   logic [QX-1:0]      quo_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // size above the bin count acts as the bin count
   assign eff_size = ({8'd0, size_ff} > BINS_W) ? BINS_W[SIZE_W-1:0] : size_ff;
   assign in_dom   = {1'b0, key_ff} < eff_size;

   // entries cleared by reset or a clear item read as zero
   assign rd_count = rd_valid_ff ? rd_data_ff : '0;
   assign mem_addr = (state_ff == ST_SCAN) ? idx_ff : key_ff[AW-1:0];

   assign div_shift = {rem_ff, 1'b0};
   assign div_diff  = div_shift - {1'b0, den_ff};
   assign div_ge    = (div_shift >= {1'b0, den_ff});
   assign div_numc  = (rem_ff > den_ff) ? den_ff : rem_ff;
   assign quo_ext   = QX'({quo_ff[QW-2:0], div_ge});

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff  <= mem[mem_addr];
      rd_valid_ff <= valid_ff[mem_addr];
   end

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      total_in      = total_ff;
      valid_in      = valid_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      prob_in       = prob_ff;
      cum_in        = cum_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      prefix_in     = prefix_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      bit_in        = bit_ff;
      second_in     = second_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_cnt_in    = out_cnt_ff;
      out_prob_in   = out_prob_ff;
      out_cum_in    = out_cum_ff;
      mem_we        = 1'b0;
      mem_wdata     = rd_count;

      if (csr_valid) begin
         size_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in = req_tuser;
               key_in  = req_tdata;
               // clear acts before the key is looked at, in domain or not
               if (req_tuser == MODE_CLEAR) begin
                  valid_in = '0;
                  total_in = '0;
               end
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            state_in = ST_UPDATE;
         end

         ST_UPDATE: begin
            status_in = STATUS_OK;
            cnt_in    = rd_count;
            second_in = 1'b0;
            if (!in_dom) begin
               status_in = STATUS_RANGE;
               cnt_in    = '0;
               prob_in   = '0;
               cum_in    = '0;
               state_in  = ST_DONE;
            end else begin
               if (mode_ff == MODE_ADD) begin
                  if (total_ff == COUNT_MAX) begin
                     status_in = STATUS_SATURATED;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_count + 32'd1;
                     cnt_in    = mem_wdata;
                     total_in  = total_ff + 32'd1;
                  end
               end else if (mode_ff == MODE_REMOVE) begin
                  if (rd_count != '0) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_count - 32'd1;
                     cnt_in    = mem_wdata;
                     total_in  = total_ff - 32'd1;
                  end
               end
               if (mem_we) begin
                  valid_in[key_ff[AW-1:0]] = 1'b1;
               end
               // probability first: uniform share when the histogram is empty
               if (total_in == '0) begin
                  rem_in = 32'd1;
                  den_in = {23'd0, eff_size};
               end else begin
                  rem_in = cnt_in;
                  den_in = total_in;
               end
               state_in = ST_DIVLD;
            end
         end

         ST_DIVLD: begin
            // integer bit: set only when numerator reaches the divisor
            quo_in   = QW'(div_numc == den_ff);
            rem_in   = (div_numc == den_ff) ? '0 : div_numc;
            bit_in   = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            rem_in = div_ge ? div_diff[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
            quo_in = {quo_ff[QW-2:0], div_ge};
            bit_in = bit_ff + CW'(1);
            if (bit_ff == LAST_BIT) begin
               if (!second_ff) begin
                  prob_in   = quo_ext[FRAC_W-1:0];
                  second_in = 1'b1;
                  if (total_ff == '0) begin
                     rem_in   = {24'd0, key_ff} + 32'd1;
                     den_in   = {23'd0, eff_size};
                     state_in = ST_DIVLD;
                  end else begin
                     idx_in    = '0;
                     prefix_in = '0;
                     state_in  = ST_SCAN;
                  end
               end else begin
                  cum_in   = quo_ext[FRAC_W-1:0];
                  state_in = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            // one read issued per cycle, each count added once its registered read returns
            pend_in = 1'b1;
            if (pend_ff) begin
               prefix_in = prefix_ff + rd_count;
            end
            if (idx_ff == key_ff[AW-1:0]) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         ST_DRAIN: begin
            rem_in   = prefix_ff + rd_count;
            den_in   = total_ff;
            state_in = ST_DIVLD;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_cnt_in    = cnt_ff;
               out_prob_in   = prob_ff;
               out_cum_in    = cum_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         total_ff     <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      cnt_ff        <= cnt_in;
      prob_ff       <= prob_in;
      cum_ff        <= cum_in;
      idx_ff        <= idx_in;
      prefix_ff     <= prefix_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      quo_ff        <= quo_in;
      bit_ff        <= bit_in;
      out_status_ff <= out_status_in;
      out_cnt_ff    <= out_cnt_in;
      out_prob_ff   <= out_prob_in;
      out_cum_ff    <= out_cum_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {6'd0, out_cum_ff, out_prob_ff, out_cnt_ff};

endmodule

FILE: rtl/hpc_checker.sv
// port-level checker of the histogram probability and cdf block, with its bind
module hpc_checker
   import hpc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [71:0]         rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   localparam logic CUM_CHECK = (FRAC_BITS <= 16);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // an accepted request blocks the next one in the cycle after it
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // out-of-domain results carry no count and no fractions
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_RANGE |-> rsp_tdata == '0)
      else $error("out-of-domain result not zero");

   // prefix through the key never falls below the key's own share
   a_cum_ge_prob: assert property (@(posedge clock) disable iff (reset)
      CUM_CHECK && rsp_tvalid && rsp_tuser != STATUS_RANGE
      |-> rsp_tdata[65:49] >= rsp_tdata[48:32])
      else $error("cumulative below probability");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind histogram_probability_cdf hpc_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_hpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
